[rtl/trace_record_block_packer_top_assert.svh]
// assertion helpers for the trace record block packer
`ifndef TRACE_RECORD_BLOCK_PACKER_TOP_ASSERT_SVH
`define TRACE_RECORD_BLOCK_PACKER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TRBP_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trbp same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define TRBP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trbp next-cycle check failed");

`endif

[rtl/trbp_pkg.sv]
`timescale 1ns / 1ps

package trbp_pkg;

	localparam int unsigned BLOCK_BYTES       = 4096;
	localparam int unsigned LENGTH_WORD_BYTES = 8;
	localparam int unsigned HEADER_BYTES      = 13;

	localparam int unsigned FILL_W   = 13;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned LEN_W    = 12;

	localparam int unsigned RES_DEPTH = 4;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_FLUSH = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		RES_HEADER    = 3'd0,
		RES_BYTE      = 3'd1,
		RES_SEALED    = 3'd2,
		RES_TOO_LARGE = 3'd3,
		RES_SURPLUS   = 3'd4
	} result_kind_t;

	typedef struct packed {
		result_kind_t          kind;
		logic [OFFSET_W-1:0]   offset;
		logic [31:0]           checksum;
		logic [63:0]           timestamp;
		logic [7:0]            cpu;
		logic [7:0]            data;
		logic [FILL_W-1:0]     sealed;
		logic                  last;
	} result_t;

endpackage

[rtl/trace_record_block_packer_top.sv]
`timescale 1ns / 1ps
// Trace record block packer. Each transfer on the input channel (start a record,
// one payload byte, or flush) is taken into an input register and worked out
// against the block counters once the result queue has two free entries; its
// results (none, one or two) go into a four-entry result queue, which drives the
// output channel one result per cycle while the output is not stalled. Input
// transfers are taken every cycle while the queue has two free entries, so the
// sustained rate is one item per cycle when each item gives one result and the
// output is not stalled; a record start that seals the block gives two results.
// The system checksum register may be written at any time the block is idle;
// cfg_ready is always high.

`include "trace_record_block_packer_top_assert.svh"

module trace_record_block_packer_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] record_checksum,
	input  logic [63:0] record_timestamp,
	input  logic [7:0]  cpu_number,
	input  logic        is_system_trace,
	input  logic [11:0] payload_length,
	input  logic [7:0]  payload_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [11:0] block_offset,
	output logic [31:0] header_checksum,
	output logic [63:0] header_timestamp,
	output logic [7:0]  header_cpu,
	output logic [7:0]  byte_out,
	output logic [12:0] sealed_length,
	output logic        last
);

	localparam int unsigned FILL_W  = trbp_pkg::FILL_W;
	localparam int unsigned LEN_W   = trbp_pkg::LEN_W;
	localparam int unsigned SUM_W   = FILL_W + 1;
	localparam int unsigned DEPTH   = trbp_pkg::RES_DEPTH;
	localparam int unsigned PTR_W   = $clog2(DEPTH);
	localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

	localparam logic [FILL_W-1:0] LEN_WORD = FILL_W'(trbp_pkg::LENGTH_WORD_BYTES);
	localparam logic [FILL_W-1:0] HDR      = FILL_W'(trbp_pkg::HEADER_BYTES);
	localparam logic [SUM_W-1:0]  BLOCK    = SUM_W'(trbp_pkg::BLOCK_BYTES);
	localparam logic [SUM_W-1:0]  ROOM_MAX =
		SUM_W'(trbp_pkg::BLOCK_BYTES - trbp_pkg::LENGTH_WORD_BYTES);

	// configuration
	logic [31:0] sys_checksum_q;

	// input register
	logic                 valid_s1;
	logic [1:0]           action_s1;
	logic [31:0]          checksum_s1;
	logic [63:0]          timestamp_s1;
	logic [7:0]           cpu_s1;
	logic                 system_s1;
	logic [LEN_W-1:0]     length_s1;
	logic [7:0]           byte_s1;

	// block counters
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [FILL_W-1:0] wpos_q, wpos_d;
	logic [LEN_W-1:0]  left_q, left_d;

	// result queue
	trbp_pkg::result_t fifo_q [DEPTH];
	logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]  count_q;

	trbp_pkg::result_t res0, res1, hdr_res, seal_res;
	logic [1:0]        n_res;
	logic              room;
	logic              process;
	logic              in_take;
	logic              pop;
	logic [SUM_W-1:0]  need;
	logic [FILL_W-1:0] base;
	trbp_pkg::result_t head;

	assign cfg_ready = 1'b1;

	assign room     = count_q <= CNT_W'(DEPTH - 2);
	assign process  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_take  = in_valid && !in_stall;
	assign pop      = (count_q != '0) && !out_stall;

	always_comb begin
		res0     = '0;
		res1     = '0;
		hdr_res  = '0;
		seal_res = '0;
		n_res    = 2'd0;
		fill_d   = fill_q;
		wpos_d   = wpos_q;
		left_d   = left_q;
		base     = fill_q;
		need     = SUM_W'(length_s1) + SUM_W'(HDR);
		case (trbp_pkg::action_t'(action_s1))
			trbp_pkg::ACT_START: begin
				if (need > ROOM_MAX) begin
					// can never fit: flagged, block fill left as it is and any open payload dropped
					res0.kind = trbp_pkg::RES_TOO_LARGE;
					res0.last = 1'b1;
					left_d    = '0;
					n_res     = 2'd1;
				end else begin
					seal_res.kind   = trbp_pkg::RES_SEALED;
					seal_res.sealed = fill_q;
					hdr_res.kind      = trbp_pkg::RES_HEADER;
					hdr_res.checksum  = system_s1 ? sys_checksum_q : checksum_s1;
					hdr_res.timestamp = timestamp_s1;
					hdr_res.cpu       = cpu_s1;
					hdr_res.last      = 1'b1;
					if ((SUM_W'(fill_q) + need) > BLOCK) begin
						base           = LEN_WORD;
						hdr_res.offset = LEN_WORD[trbp_pkg::OFFSET_W-1:0];
						res0           = seal_res;
						res1           = hdr_res;
						n_res          = 2'd2;
					end else begin
						hdr_res.offset = fill_q[trbp_pkg::OFFSET_W-1:0];
						res0           = hdr_res;
						n_res          = 2'd1;
					end
					wpos_d = base + HDR;
					fill_d = base + need[FILL_W-1:0];
					left_d = length_s1;
				end
			end
			trbp_pkg::ACT_BYTE: begin
				n_res     = 2'd1;
				res0.last = 1'b1;
				if (left_q != '0) begin
					res0.kind   = trbp_pkg::RES_BYTE;
					res0.offset = wpos_q[trbp_pkg::OFFSET_W-1:0];
					res0.data   = byte_s1;
					wpos_d      = wpos_q + FILL_W'(1);
					left_d      = left_q - LEN_W'(1);
				end else begin
					res0.kind = trbp_pkg::RES_SURPLUS;
				end
			end
			trbp_pkg::ACT_FLUSH: begin
				// only a block that holds data is sealed
				if (fill_q > LEN_WORD) begin
					res0.kind   = trbp_pkg::RES_SEALED;
					res0.sealed = fill_q;
					res0.last   = 1'b1;
					n_res       = 2'd1;
					fill_d      = LEN_WORD;
					wpos_d      = LEN_WORD;
					left_d      = '0;
				end
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_checksum_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			sys_checksum_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || process) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1    <= action;
			checksum_s1  <= record_checksum;
			timestamp_s1 <= record_timestamp;
			cpu_s1       <= cpu_number;
			system_s1    <= is_system_trace;
			length_s1    <= payload_length;
			byte_s1      <= payload_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= LEN_WORD;
			wpos_q <= LEN_WORD;
			left_q <= '0;
		end else if (process) begin
			fill_q <= fill_d;
			wpos_q <= wpos_d;
			left_q <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (process) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			count_q <= count_q + (process ? CNT_W'(n_res) : '0) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (process && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (process && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

	assign head             = fifo_q[rd_ptr_q];
	assign out_valid        = count_q != '0;
	assign result_kind      = head.kind;
	assign block_offset     = head.offset;
	assign header_checksum  = head.checksum;
	assign header_timestamp = head.timestamp;
	assign header_cpu       = head.cpu;
	assign byte_out         = head.data;
	assign sealed_length    = head.sealed;
	assign last             = head.last;

	// queue never overfills: work only goes ahead with two entries free
	`TRBP_ASSERT_IMP(a_queue_bound, 1'b1, count_q <= CNT_W'(DEPTH))

	// the used length never leaves the block
	`TRBP_ASSERT_IMP(a_fill_range, 1'b1, (fill_q >= LEN_WORD) && (SUM_W'(fill_q) <= BLOCK))

	// an open payload always ends exactly at the reserved fill level
	`TRBP_ASSERT_IMP(a_payload_end, left_q != '0, (SUM_W'(wpos_q) + SUM_W'(left_q)) == SUM_W'(fill_q))

	// a stalled input item is worked out as soon as a pop leaves two queue entries free
	`TRBP_ASSERT_NEXT(a_stall_release, in_stall && pop && count_q == CNT_W'(DEPTH - 1), !in_stall || process)

endmodule
